// ----- sv/scsu_pkg.sv -----
// Shared types, tag codes and window tables for the SCSU encoder.
package scsu_pkg;

  localparam int MAX_BYTES   = 5;
  localparam int LEN_W       = $clog2(MAX_BYTES + 1);
  localparam int IDX_W       = $clog2(MAX_BYTES);
  localparam int WIN_COUNT   = 8;
  localparam int WIN_W       = $clog2(WIN_COUNT);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [20:0] CP_MAX    = 21'h10FFFF;
  localparam logic [15:0] HIGH_BASE = 16'hD7C0;
  localparam logic [15:0] BOM       = 16'hFEFF;
  localparam logic [15:0] PRIV_LO   = 16'hE000;
  localparam logic [15:0] PRIV_HI   = 16'hF2FF;
  localparam logic [31:0] CTRL_PASS = 32'h0000_2601;

  localparam logic [7:0] TAG_SQ0 = 8'h01;
  localparam logic [7:0] TAG_SQU = 8'h0E;
  localparam logic [7:0] TAG_SCU = 8'h0F;
  localparam logic [7:0] TAG_SC0 = 8'h10;
  localparam logic [7:0] TAG_UC0 = 8'hE0;
  localparam logic [7:0] TAG_UQU = 8'hF0;

  localparam logic [15:0] DYN_OFFSET [WIN_COUNT] = '{
    16'h0080, 16'h00C0, 16'h0400, 16'h0600, 16'h0900, 16'h3040, 16'h30A0, 16'hFF00
  };
  localparam logic [15:0] STATIC_OFFSET [WIN_COUNT] = '{
    16'h0000, 16'h0080, 16'h0100, 16'h0300, 16'h2000, 16'h2080, 16'h2100, 16'h3000
  };

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] seq;
    logic [LEN_W-1:0]          len;
  } entry_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// ----- sv/scsu_unicode_encoder_core.sv -----
// SCSU encoder top level: one code point in, one to five encoded bytes out (none if out of range).
// First byte of an item is offered once the item sits at the head of the queue.
// Throughput: one byte per cycle on the output while byte_stall is low; an item
// holds the output until all its bytes are taken through the single byte-wide port.
// Input takes one item per cycle while the four-entry queue has room.
// Reset (rst, synchronous): single-byte mode, window 0, queue empty.
module scsu_unicode_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cp_valid,
  output logic        cp_stall,
  input  logic [20:0] code_point,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  out_byte,
  output logic        last_byte
);

  // Front classifies each point against the mode and windows and builds its
  // complete byte sequence in the cycle it is accepted. Out-of-range points
  // are taken and dropped.
  logic                q_push;
  scsu_pkg::entry_t    q_push_entry;
  logic                q_pop;
  scsu_pkg::entry_t    q_head;
  scsu_pkg::q_status_t q_stat;

  scsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cp_valid   (cp_valid),
    .cp_stall   (cp_stall),
    .code_point (code_point),
    .queue_full (q_stat.full),
    .push       (q_push),
    .push_entry (q_push_entry)
  );

  // Queue decouples the two sides: the front keeps taking items while the
  // back is held by byte_stall, as long as the queue has room.
  scsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_stat)
  );

  // Back walks the head entry byte by byte and retires it on its last byte.
  scsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .status     (q_stat),
    .pop        (q_pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .last_byte  (last_byte)
  );

`ifndef NO_ASSERTIONS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_stat.full))
    else $error("push into a full queue");

  a_pop_on_last_only: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (byte_valid && !byte_stall && last_byte))
    else $error("queue popped before the last byte was taken");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= scsu_pkg::QCNT_W'(scsu_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_head_len_legal: assert property (@(posedge clk) disable iff (rst)
    !q_stat.empty |-> (q_head.len != '0 &&
                       q_head.len <= scsu_pkg::LEN_W'(scsu_pkg::MAX_BYTES)))
    else $error("queued sequence length out of range");
`endif

endmodule

// ----- sv/scsu_front.sv -----
// Front end: accept code points, track mode and window, build byte sequences.
module scsu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cp_valid,
  output logic                cp_stall,
  input  logic [20:0]         code_point,
  input  logic                queue_full,
  output logic                push,
  output scsu_pkg::entry_t    push_entry
);

  logic                        unicode_mode, unicode_mode_next;
  logic [scsu_pkg::WIN_W-1:0]  active_window, active_window_next;

  logic [15:0] cp16;
  logic        accept, in_range, is_bmp, is_ascii, is_ctrl_quoted, is_priv;
  logic [16:0] dyn_diff [scsu_pkg::WIN_COUNT];
  logic [16:0] sta_diff [scsu_pkg::WIN_COUNT];
  logic [scsu_pkg::WIN_COUNT-1:0] dyn_hit, sta_hit;
  logic        dyn_any, sta_any;
  logic [scsu_pkg::WIN_W-1:0] dyn_sel, sta_sel;
  logic [7:0]  dyn_byte, sta_byte, act_byte;
  logic [15:0] hs, ls;
  scsu_pkg::entry_t e;

  assign cp16     = code_point[15:0];
  assign accept   = cp_valid && !cp_stall;
  assign cp_stall = queue_full;
  assign in_range = code_point <= scsu_pkg::CP_MAX;
  assign is_bmp   = code_point[20:16] == 5'd0;
  assign is_ascii = cp16[15:7] == 9'd0;
  assign is_ctrl_quoted = (cp16[15:5] == 11'd0) && !scsu_pkg::CTRL_PASS[cp16[4:0]];
  assign is_priv  = (cp16 >= scsu_pkg::PRIV_LO) && (cp16 <= scsu_pkg::PRIV_HI);
  assign hs       = scsu_pkg::HIGH_BASE + {5'd0, code_point[20:10]};
  assign ls       = {6'b110111, code_point[9:0]};

  // Window hits: all sixteen compares run side by side, lowest index wins.
  always_comb begin
    dyn_any = 1'b0;
    sta_any = 1'b0;
    dyn_sel = '0;
    sta_sel = '0;
    for (int i = 0; i < scsu_pkg::WIN_COUNT; i++) begin
      dyn_diff[i] = {1'b0, cp16} - {1'b0, scsu_pkg::DYN_OFFSET[i]};
      sta_diff[i] = {1'b0, cp16} - {1'b0, scsu_pkg::STATIC_OFFSET[i]};
      dyn_hit[i]  = !dyn_diff[i][16] && (dyn_diff[i][15:7] == 9'd0);
      sta_hit[i]  = !sta_diff[i][16] && (sta_diff[i][15:7] == 9'd0);
    end
    for (int i = scsu_pkg::WIN_COUNT - 1; i >= 0; i--) begin
      if (dyn_hit[i]) begin
        dyn_any = 1'b1;
        dyn_sel = scsu_pkg::WIN_W'(i);
      end
      if (sta_hit[i]) begin
        sta_any = 1'b1;
        sta_sel = scsu_pkg::WIN_W'(i);
      end
    end
  end

  assign dyn_byte = {1'b1, dyn_diff[dyn_sel][6:0]};
  assign sta_byte = {1'b0, sta_diff[sta_sel][6:0]};
  assign act_byte = {1'b1, dyn_diff[active_window][6:0]};

  always_comb begin
    e                  = '0;
    unicode_mode_next  = unicode_mode;
    active_window_next = active_window;
    if (!is_bmp) begin
      // Surrogate halves lie in no window and outside the private-use range.
      if (!unicode_mode) begin
        e.seq[0] = scsu_pkg::TAG_SCU;
        e.seq[1] = hs[15:8];
        e.seq[2] = hs[7:0];
        e.seq[3] = ls[15:8];
        e.seq[4] = ls[7:0];
        e.len    = scsu_pkg::LEN_W'(5);
        unicode_mode_next = 1'b1;
      end else begin
        e.seq[0] = hs[15:8];
        e.seq[1] = hs[7:0];
        e.seq[2] = ls[15:8];
        e.seq[3] = ls[7:0];
        e.len    = scsu_pkg::LEN_W'(4);
      end
    end else if (!unicode_mode) begin
      if (is_ascii) begin
        if (is_ctrl_quoted) begin
          e.seq[0] = scsu_pkg::TAG_SQ0;
          e.seq[1] = cp16[7:0];
          e.len    = scsu_pkg::LEN_W'(2);
        end else begin
          e.seq[0] = cp16[7:0];
          e.len    = scsu_pkg::LEN_W'(1);
        end
      end else if (dyn_hit[active_window]) begin
        e.seq[0] = act_byte;
        e.len    = scsu_pkg::LEN_W'(1);
      end else if (dyn_any) begin
        e.seq[0] = scsu_pkg::TAG_SC0 + {5'd0, dyn_sel};
        e.seq[1] = dyn_byte;
        e.len    = scsu_pkg::LEN_W'(2);
        active_window_next = dyn_sel;
      end else if (sta_any) begin
        e.seq[0] = scsu_pkg::TAG_SQ0 + {5'd0, sta_sel};
        e.seq[1] = sta_byte;
        e.len    = scsu_pkg::LEN_W'(2);
      end else if (cp16 == scsu_pkg::BOM) begin
        e.seq[0] = scsu_pkg::TAG_SQU;
        e.seq[1] = cp16[15:8];
        e.seq[2] = cp16[7:0];
        e.len    = scsu_pkg::LEN_W'(3);
      end else begin
        e.seq[0] = scsu_pkg::TAG_SCU;
        unicode_mode_next = 1'b1;
        if (is_priv) begin
          e.seq[1] = scsu_pkg::TAG_UQU;
          e.seq[2] = cp16[15:8];
          e.seq[3] = cp16[7:0];
          e.len    = scsu_pkg::LEN_W'(4);
        end else begin
          e.seq[1] = cp16[15:8];
          e.seq[2] = cp16[7:0];
          e.len    = scsu_pkg::LEN_W'(3);
        end
      end
    end else begin
      if (is_ascii) begin
        e.seq[0] = scsu_pkg::TAG_UC0 + {5'd0, active_window};
        unicode_mode_next = 1'b0;
        if (is_ctrl_quoted) begin
          e.seq[1] = scsu_pkg::TAG_SQ0;
          e.seq[2] = cp16[7:0];
          e.len    = scsu_pkg::LEN_W'(3);
        end else begin
          e.seq[1] = cp16[7:0];
          e.len    = scsu_pkg::LEN_W'(2);
        end
      end else if (dyn_any) begin
        e.seq[0] = scsu_pkg::TAG_UC0 + {5'd0, dyn_sel};
        e.seq[1] = dyn_byte;
        e.len    = scsu_pkg::LEN_W'(2);
        active_window_next = dyn_sel;
        unicode_mode_next  = 1'b0;
      end else if (is_priv) begin
        e.seq[0] = scsu_pkg::TAG_UQU;
        e.seq[1] = cp16[15:8];
        e.seq[2] = cp16[7:0];
        e.len    = scsu_pkg::LEN_W'(3);
      end else begin
        e.seq[0] = cp16[15:8];
        e.seq[1] = cp16[7:0];
        e.len    = scsu_pkg::LEN_W'(2);
      end
    end
  end

  // Drop out-of-range points: no push, no state change.
  assign push       = accept && in_range;
  assign push_entry = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      unicode_mode  <= 1'b0;
      active_window <= '0;
    end else if (push) begin
      unicode_mode  <= unicode_mode_next;
      active_window <= active_window_next;
    end
  end

endmodule

// ----- sv/scsu_queue.sv -----
// Short queue of encoded byte sequences between the front and back ends.
module scsu_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  scsu_pkg::entry_t     push_entry,
  input  logic                 pop,
  output scsu_pkg::entry_t     head,
  output scsu_pkg::q_status_t  status
);

  scsu_pkg::entry_t             slots [scsu_pkg::QUEUE_DEPTH];
  logic [scsu_pkg::QPTR_W-1:0]  wr_ptr, wr_ptr_next;
  logic [scsu_pkg::QPTR_W-1:0]  rd_ptr, rd_ptr_next;
  logic [scsu_pkg::QCNT_W-1:0]  count, count_next;

  localparam logic [scsu_pkg::QPTR_W-1:0] LAST_SLOT = scsu_pkg::QPTR_W'(scsu_pkg::QUEUE_DEPTH - 1);

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = count == scsu_pkg::QCNT_W'(scsu_pkg::QUEUE_DEPTH);
  assign status.empty = count == '0;
  assign status.count = count;

endmodule

// ----- sv/scsu_back.sv -----
// Back end: send the head sequence one byte at a time, mark the last byte.
module scsu_back (
  input  logic                 clk,
  input  logic                 rst,
  input  scsu_pkg::entry_t     head,
  input  scsu_pkg::q_status_t  status,
  output logic                 pop,
  output logic                 byte_valid,
  input  logic                 byte_stall,
  output logic [7:0]           out_byte,
  output logic                 last_byte
);

  logic [scsu_pkg::IDX_W-1:0] idx, idx_next;
  logic                       sent;

  assign byte_valid = !status.empty;
  assign out_byte   = head.seq[idx];
  assign last_byte  = (scsu_pkg::LEN_W'(idx) + scsu_pkg::LEN_W'(1)) == head.len;
  assign sent       = byte_valid && !byte_stall;
  assign pop        = sent && last_byte;

  always_comb begin
    idx_next = idx;
    if (sent) begin
      idx_next = last_byte ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

endmodule

// ----- dv/scsu_unicode_encoder_core_tb.sv -----
// Self-checking testbench for the SCSU encoder core: directed table, then random code points.
`timescale 1ns / 100ps

module scsu_unicode_encoder_core_tb;
  import scsu_pkg::*;

  // One byte of the encoded stream as it leaves the block.
  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } scsu_byte_t;

  // One row of stimulus. When typed is set, seq/count hold the bytes read
  // straight off the encoding rules; otherwise the encoder model decides.
  typedef struct packed {
    logic [20:0]     cp;
    logic            typed;
    logic [2:0]      count;
    logic [0:4][7:0] seq;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 25;
  localparam int RANDOM_POINTS = 75;

  logic        clk;
  logic        rst        = 1'b1;
  logic        cp_valid   = 1'b0;
  logic        cp_stall;
  logic [20:0] code_point = '0;
  logic        byte_valid;
  logic        byte_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        last_byte;

  // Encoder model state: mode flag and active dynamic window.
  logic        model_unicode;
  logic [2:0]  model_window;
  logic [7:0]  encoded_bytes[$];

  // Bytes still owed by the block, oldest first.
  scsu_byte_t  expected_bytes[$];
  scsu_byte_t  want;

  int          mismatches = 0;
  bit          no_idle    = 1'b0;

  scsu_unicode_encoder_core dut (
    .clk       (clk),
    .rst       (rst),
    .cp_valid  (cp_valid),
    .cp_stall  (cp_stall),
    .code_point(code_point),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run (about 105 items, five bytes
  // each, with random stalls on both sides).
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d bytes still expected", $time, expected_bytes.size());
    $display("Simulation FAILED");
    $finish;
  end

  // Index of the dynamic window holding cp, or -1.
  function automatic int dyn_window_of(logic [15:0] cp);
    for (int i = 0; i < WIN_COUNT; i++) begin
      if (cp >= DYN_OFFSET[i] && (cp - DYN_OFFSET[i]) <= 16'h7F) return i;
    end
    return -1;
  endfunction

  // Encode one BMP unit (or surrogate half) into encoded_bytes, walking the
  // mode switches until the unit has been fully emitted.
  function automatic void encode_bmp_unit(logic [15:0] cp);
    logic [15:0] off;
    int          w;
    int          s;
    bit          done;
    done = 1'b0;
    while (!done) begin
      w = dyn_window_of(cp);
      if (!model_unicode) begin
        off = DYN_OFFSET[model_window];
        s   = -1;
        for (int i = WIN_COUNT - 1; i >= 0; i--) begin
          if (cp >= STATIC_OFFSET[i] && (cp - STATIC_OFFSET[i]) <= 16'h7F) s = i;
        end
        done = 1'b1;
        if (cp < 16'h20) begin
          // only NUL, TAB, LF and CR pass through unquoted
          if (!CTRL_PASS[cp[4:0]]) encoded_bytes.push_back(TAG_SQ0);
          encoded_bytes.push_back(cp[7:0]);
        end else if (cp <= 16'h7F) begin
          encoded_bytes.push_back(cp[7:0]);
        end else if (cp >= off && (cp - off) <= 16'h7F) begin
          encoded_bytes.push_back(8'(16'h80 + (cp - off)));
        end else if (w >= 0) begin
          encoded_bytes.push_back(8'(TAG_SC0 + w));
          encoded_bytes.push_back(8'(16'h80 + (cp - DYN_OFFSET[w])));
          model_window = 3'(w);
        end else if (s >= 0) begin
          encoded_bytes.push_back(8'(TAG_SQ0 + s));
          encoded_bytes.push_back(8'(cp - STATIC_OFFSET[s]));
        end else if (cp == BOM) begin
          encoded_bytes.push_back(TAG_SQU);
          encoded_bytes.push_back(8'hFE);
          encoded_bytes.push_back(8'hFF);
        end else begin
          encoded_bytes.push_back(TAG_SCU);
          model_unicode = 1'b1;
          done = 1'b0;
        end
      end else if (cp <= 16'h7F) begin
        encoded_bytes.push_back(8'(TAG_UC0 + model_window));
        model_unicode = 1'b0;
      end else if (w >= 0) begin
        encoded_bytes.push_back(8'(TAG_UC0 + w));
        model_window  = 3'(w);
        model_unicode = 1'b0;
      end else begin
        if (cp >= PRIV_LO && cp <= PRIV_HI) encoded_bytes.push_back(TAG_UQU);
        encoded_bytes.push_back(cp[15:8]);
        encoded_bytes.push_back(cp[7:0]);
        done = 1'b1;
      end
    end
  endfunction

  // Full code point: range check, surrogate split, five-byte cap.
  function automatic void encode_code_point(logic [20:0] cp);
    logic [20:0] high_half;
    encoded_bytes.delete();
    if (cp > CP_MAX) return;
    if (cp > 21'h00FFFF) begin
      high_half = 21'(HIGH_BASE) + (cp >> 10);
      encode_bmp_unit(high_half[15:0]);
      encode_bmp_unit(16'hDC00 + {6'd0, cp[9:0]});
    end else begin
      encode_bmp_unit(cp[15:0]);
    end
    while (encoded_bytes.size() > MAX_BYTES) void'(encoded_bytes.pop_back());
  endfunction

  // Random code point from a rough category; the mix favors window hits so
  // that single-byte runs and window switches happen often.
  function automatic logic [20:0] pick_point(int cat);
    if (cat < 10) return 21'($urandom_range(0, 31));
    if (cat < 25) return 21'($urandom_range(32, 127));
    if (cat < 45) return 21'(DYN_OFFSET[$urandom_range(0, 7)] + $urandom_range(0, 127));
    if (cat < 55) return 21'(STATIC_OFFSET[$urandom_range(0, 7)] + $urandom_range(0, 127));
    if (cat < 58) return 21'(BOM);
    if (cat < 70) return 21'($urandom_range(16'h0080, 16'hFFFF));
    if (cat < 77) return 21'($urandom_range(16'hDFF0, 16'hF30F));
    if (cat < 82) return 21'($urandom_range(16'hD800, 16'hDFFF));
    if (cat < 95) return 21'($urandom_range(21'h010000, CP_MAX));
    return 21'($urandom_range(21'h110000, 21'h1FFFFF));
  endfunction

  // Offer one item; hold it until taken, then record what it should produce.
  task automatic send_item(input stim_row_t row);
    while (!no_idle && $urandom_range(0, 99) < 27) begin
      cp_valid <= 1'b0;
      @(posedge clk);
    end
    cp_valid   <= 1'b1;
    code_point <= row.cp;
    @(posedge clk);
    while (cp_stall) @(posedge clk);
    encode_code_point(row.cp);
    if (row.typed) begin
      for (int k = 0; k < row.count; k++)
        expected_bytes.push_back('{row.seq[k], k == row.count - 1});
    end else begin
      foreach (encoded_bytes[k])
        expected_bytes.push_back('{encoded_bytes[k], k == encoded_bytes.size() - 1});
    end
  endtask

  // Drop valid and hold off until every owed byte has come out.
  task automatic hold_until_drained();
    cp_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  // Output side: check each taken byte against the oldest expectation, and
  // stall at random except during the quiet stretch.
  always @(posedge clk) begin
    if (!rst && byte_valid && !byte_stall) begin
      if (expected_bytes.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                 $time, out_byte, last_byte);
      end else begin
        want = expected_bytes.pop_front();
        if (out_byte !== want.value || last_byte !== want.last) begin
          mismatches++;
          $display("%0t: byte mismatch, expected %02h last %0b, actual %02h last %0b",
                   $time, want.value, want.last, out_byte, last_byte);
        end
      end
    end
    byte_stall <= !no_idle && ($urandom_range(0, 99) < 27);
  end

  // Directed rows, in order; state carries from row to row.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{21'h000000, 1'b1, 3'd1, 40'h00_00_00_00_00},  // NUL passes through
    '{21'h000001, 1'b1, 3'd2, 40'h01_01_00_00_00},  // other C0 gets quoted
    '{21'h000009, 1'b1, 3'd1, 40'h09_00_00_00_00},  // TAB passes through
    '{21'h00001F, 1'b1, 3'd2, 40'h01_1F_00_00_00},  // top of C0, quoted
    '{21'h00007F, 1'b1, 3'd1, 40'h7F_00_00_00_00},  // top of ASCII
    '{21'h0000FF, 1'b1, 3'd1, 40'hFF_00_00_00_00},  // top of Latin-1 window
    '{21'h000410, 1'b1, 3'd2, 40'h12_90_00_00_00},  // switch to Cyrillic window
    '{21'h000150, 1'b1, 3'd2, 40'h03_50_00_00_00},  // static window quote
    '{21'h00FEFF, 1'b1, 3'd3, 40'h0E_FE_FF_00_00},  // byte order mark
    '{21'h004E00, 1'b1, 3'd3, 40'h0F_4E_00_00_00},  // enter Unicode mode
    '{21'h00E123, 1'b1, 3'd3, 40'hF0_E1_23_00_00},  // private use, UQU quote
    '{21'h000005, 1'b0, 3'd0, 40'h0},               // C0 while in Unicode mode
    '{21'h00FFFF, 1'b0, 3'd0, 40'h0},               // top of BMP
    '{21'h00FF20, 1'b0, 3'd0, 40'h0},               // leave Unicode via window 7
    '{21'h110000, 1'b1, 3'd0, 40'h0},               // just past range, no output
    '{21'h1FFFFF, 1'b1, 3'd0, 40'h0},               // all ones, no output
    '{21'h10FFFF, 1'b1, 3'd5, 40'h0F_DB_FF_DF_FF},  // largest point, five bytes
    '{21'h010000, 1'b0, 3'd0, 40'h0},               // smallest supplementary
    '{21'h00D800, 1'b0, 3'd0, 40'h0},               // lone surrogate
    '{21'h00F2FF, 1'b0, 3'd0, 40'h0},               // top of UQU range
    '{21'h003042, 1'b0, 3'd0, 40'h0},               // Hiragana window from Unicode
    '{21'h0030A5, 1'b0, 3'd0, 40'h0},               // Katakana window switch
    '{21'h002010, 1'b0, 3'd0, 40'h0},               // punctuation static window
    '{21'h00000D, 1'b0, 3'd0, 40'h0},               // CR passes through
    '{21'h000120, 1'b0, 3'd0, 40'h0}                // Latin Extended window
  };

  initial begin
    stim_row_t row;
    int        sent;
    int        run_left;
    int        cat;
    bit        drained;

    model_unicode = 1'b0;
    model_window  = '0;
    sent     = 0;
    run_left = 0;
    cat      = 0;
    drained  = 1'b0;

    // Hold reset, then release.
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    // Let the directed bytes drain before random traffic starts.
    hold_until_drained();

    // Random part: runs of one category so window hits repeat; out-of-range
    // points are noise and do not count toward the total.
    while (sent < RANDOM_POINTS) begin
      if (run_left == 0) begin
        cat      = $urandom_range(0, 99);
        run_left = $urandom_range(1, 4);
      end
      run_left--;
      row       = '0;
      row.cp    = pick_point(cat);
      no_idle   = (sent >= 35 && sent < 65);
      if (sent == 20 && !drained) begin
        drained = 1'b1;
        hold_until_drained();
      end
      send_item(row);
      if (row.cp <= CP_MAX) sent++;
    end

    // Wait out the tail, then keep watching the output for any stray byte.
    hold_until_drained();
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/scsu_pkg.sv
sv/scsu_front.sv
sv/scsu_queue.sv
sv/scsu_back.sv
sv/scsu_unicode_encoder_core.sv
dv/scsu_unicode_encoder_core_tb.sv
